[design/arpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache package
// Shared widths, command codes and the cache entry layout.
// ----------------------------------------------------------------------------
package arpc_pkg;

    localparam int DEF_ENTRIES = 8;

    localparam int CMD_W = 2;
    localparam int IP_W  = 32;
    localparam int MAC_W = 48;
    localparam int CNT_W = 8;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INVAL  = 2'd2;

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;
    localparam logic [CNT_W-1:0] COUNT_ONE = 8'd1;

    typedef struct packed {
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic [CNT_W-1:0] cnt;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

[design/arpc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache channel interfaces
// Request and response channels with valid/ready transfer handshake.
// ----------------------------------------------------------------------------
interface arpc_req_if
    import arpc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [IP_W-1:0]  ip_addr;
    logic [MAC_W-1:0] new_mac;

    modport source (output valid, cmd, ip_addr, new_mac, input ready);
    modport sink   (input valid, cmd, ip_addr, new_mac, output ready);
endinterface

interface arpc_rsp_if
    import arpc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             hit;
    logic [MAC_W-1:0] found_mac;

    modport source (output valid, hit, found_mac, input ready);
    modport sink   (input valid, hit, found_mac, output ready);
endinterface

[design/arpc_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/arpc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache controller
// Scans the entry RAM for match and least-used slot, then writes back on set or on a hitting invalidate.
// ----------------------------------------------------------------------------
module arpc_ctrl
    import arpc_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    arpc_req_if.sink           req,
    arpc_rsp_if.source         rsp,
    output logic               ram_we,
    output logic [IDX_W-1:0]   ram_waddr,
    output logic [ENTRY_W-1:0] ram_wdata,
    output logic               ram_re,
    output logic [IDX_W-1:0]   ram_raddr,
    input  logic [ENTRY_W-1:0] ram_rdata
);

    localparam int SCAN_W = $clog2(ENTRIES + 1);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(ENTRIES - 1);
    localparam logic [SCAN_W-1:0] SCAN_END  = SCAN_W'(ENTRIES);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [IP_W-1:0]   ip_reg, ip_next;
    logic [MAC_W-1:0]  mac_reg, mac_next;
    logic [SCAN_W-1:0] iss_reg, iss_next;
    logic              cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic              hit_reg, hit_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [MAC_W-1:0]  found_reg, found_next;
    logic [CNT_W-1:0]  hcnt_reg, hcnt_next;
    logic [CNT_W-1:0]  min_cnt_reg, min_cnt_next;
    logic [IDX_W-1:0]  min_idx_reg, min_idx_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_hit_reg, out_hit_next;
    logic [MAC_W-1:0]  out_mac_reg, out_mac_next;

    entry_t            ent;
    entry_t            wr_ent;
    logic              issue;
    logic              last;
    logic              out_free;
    logic              load_out;

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.hit       = out_hit_reg;
    assign rsp.found_mac = out_mac_reg;

    assign issue     = (state_reg == ST_SCAN) && (iss_reg < SCAN_END);
    assign ram_re    = issue;
    assign ram_raddr = iss_reg[IDX_W-1:0];
    assign last      = cmp_valid_reg && (cmp_idx_reg == LAST_IDX);
    assign out_free  = !out_valid_reg || rsp.ready;
    assign ent       = valid_reg[cmp_idx_reg] ? entry_t'(ram_rdata) : '0;
    assign ram_wdata = wr_ent;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        ip_next        = ip_reg;
        mac_next       = mac_reg;
        iss_next       = iss_reg;
        cmp_valid_next = issue;
        cmp_idx_next   = iss_reg[IDX_W-1:0];
        hit_next       = hit_reg;
        slot_next      = slot_reg;
        found_next     = found_reg;
        hcnt_next      = hcnt_reg;
        min_cnt_next   = min_cnt_reg;
        min_idx_next   = min_idx_reg;
        valid_next     = valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = slot_reg;
        wr_ent         = '0;
        load_out       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next   = req.cmd;
                    ip_next    = req.ip_addr;
                    mac_next   = req.new_mac;
                    iss_next   = '0;
                    hit_next   = 1'b0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    iss_next = iss_reg + SCAN_W'(1);
                end
                if (cmp_valid_reg)
                begin
                    if (!hit_reg && (ent.ip == ip_reg))
                    begin
                        hit_next   = 1'b1;
                        slot_next  = cmp_idx_reg;
                        found_next = ent.mac;
                        hcnt_next  = ent.cnt;
                    end
                    if ((cmp_idx_reg == '0) || (ent.cnt < min_cnt_reg))
                    begin
                        min_cnt_next = ent.cnt;
                        min_idx_next = cmp_idx_reg;
                    end
                end
                if (last)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                case (cmd_reg)
                    CMD_SET:
                    begin
                        ram_we     = 1'b1;
                        wr_ent.ip  = ip_reg;
                        wr_ent.mac = mac_reg;
                        if (hit_reg)
                        begin
                            wr_ent.cnt = (hcnt_reg == COUNT_MAX) ? COUNT_MAX
                                                                 : hcnt_reg + COUNT_ONE;
                        end
                        else
                        begin
                            ram_waddr  = min_idx_reg;
                            wr_ent.cnt = COUNT_ONE;
                        end
                    end
                    CMD_INVAL:
                    begin
                        ram_we = hit_reg;
                    end
                    default:
                    begin
                        ram_we = 1'b0;
                    end
                endcase
                if (ram_we)
                begin
                    valid_next[ram_waddr] = 1'b1;
                end
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        out_hit_next   = out_hit_reg;
        out_mac_next   = out_mac_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_hit_next   = hit_reg;
            out_mac_next   = ((cmd_reg == CMD_LOOKUP) && hit_reg) ? found_reg : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iss_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            hit_reg       <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_reg       <= iss_next;
            cmp_valid_reg <= cmp_valid_next;
            hit_reg       <= hit_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        ip_reg      <= ip_next;
        mac_reg     <= mac_next;
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
        found_reg   <= found_next;
        hcnt_reg    <= hcnt_next;
        min_cnt_reg <= min_cnt_next;
        min_idx_reg <= min_idx_next;
        out_hit_reg <= out_hit_next;
        out_mac_reg <= out_mac_next;
    end

`ifndef SYNTHESIS
    a_cmp_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_valid_reg |-> (state_reg == ST_SCAN))
        else $error("compare data outside scan");

    a_we_legal: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_WRITE) &&
                   ((cmd_reg == CMD_SET) || ((cmd_reg == CMD_INVAL) && hit_reg)))
        else $error("unexpected entry write");

    a_mac_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.found_mac != '0)) |-> rsp.hit)
        else $error("nonzero MAC without hit");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (iss_reg <= SCAN_END))
        else $error("scan counter overrun");
`endif

endmodule

[design/arp_cache_lfu.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache with least-frequently-used replacement
// Maps IPv4 to MAC addresses; lookup, set and invalidate commands.
// ----------------------------------------------------------------------------
// One request at a time: a new request is accepted only in the idle state, after
//   the previous response is loaded, owing to the serial scan of the entry RAM
//   through its single read port.
// A finished response waits in an output register; the scan does not stall.
// Reset clears all per-entry valid bits at once; invalid entries read as zero.
// ----------------------------------------------------------------------------
module arp_cache_lfu
    import arpc_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
) (
    input  logic       clk,
    input  logic       rst_n,
    arpc_req_if.sink   req,
    arpc_rsp_if.source rsp
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    arpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES),
        .AW    (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    arpc_ctrl #(
        .ENTRIES (ENTRIES),
        .IDX_W   (IDX_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache testbench
// Drives lookup, set, invalidate and unused commands into the cache while
// an in-bench copy of the table predicts every response. Runs directed
// corner cases, a use-count saturation run and random traffic under several
// sender idle and receiver stall patterns.
// ----------------------------------------------------------------------------
module tb;
    import arpc_pkg::*;

    localparam int CLK_PERIOD  = 20;
    localparam int ENTRIES     = DEF_ENTRIES;
    localparam int POOL        = 12;
    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 135;

    localparam logic [CMD_W-1:0] CMD_RSVD = 2'd3;

    typedef struct packed {
        logic             hit;
        logic [MAC_W-1:0] mac;
    } arp_reply_t;

    logic clk = 1'b0;
    logic rst_n;

    arpc_req_if req ();
    arpc_rsp_if rsp ();

    arp_cache_lfu #(.ENTRIES(ENTRIES)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    entry_t     cache_tab [ENTRIES];
    arp_reply_t reply_q [$];
    arp_reply_t head_reply;
    logic [IP_W-1:0] ip_pool [POOL];

    int src_idle_pct  = 0;
    int rsp_stall_pct = 0;
    int errors        = 0;
    int n_sent        = 0;
    int n_checked     = 0;
    int n_hits        = 0;
    int idle_cycles   = 0;
    int cmd_seen [4]  = '{0, 0, 0, 0};

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic void flag_error(string msg);
        errors++;
        if (errors <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    function automatic int cache_find(logic [IP_W-1:0] ip);
        int slot;
        slot = ENTRIES;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (cache_tab[i].ip == ip)
                slot = i;
        end
        return slot;
    endfunction

    // Applies one command to the local table and returns the response it causes.
    function automatic arp_reply_t cache_apply(logic [CMD_W-1:0] cmd, logic [IP_W-1:0] ip,
                                               logic [MAC_W-1:0] mac);
        int slot;
        int victim;
        arp_reply_t r;
        slot   = cache_find(ip);
        r.hit  = (slot < ENTRIES);
        r.mac  = '0;
        victim = 0;
        case (cmd)
            CMD_LOOKUP:
            begin
                if (r.hit)
                    r.mac = cache_tab[slot].mac;
            end
            CMD_SET:
            begin
                if (r.hit)
                begin
                    if (cache_tab[slot].cnt != COUNT_MAX)
                        cache_tab[slot].cnt = cache_tab[slot].cnt + 1'b1;
                    cache_tab[slot].mac = mac;
                end
                else
                begin
                    for (int i = 1; i < ENTRIES; i++)
                    begin
                        if (cache_tab[i].cnt < cache_tab[victim].cnt)
                            victim = i;
                    end
                    cache_tab[victim].ip  = ip;
                    cache_tab[victim].mac = mac;
                    cache_tab[victim].cnt = COUNT_ONE;
                end
            end
            CMD_INVAL:
            begin
                if (r.hit)
                    cache_tab[slot] = '0;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[MAC_W-1:0];
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_req(logic [CMD_W-1:0] cmd, logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid   <= 1'b1;
        req.cmd     <= cmd;
        req.ip_addr <= ip;
        req.new_mac <= mac;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        reply_q.push_back(cache_apply(cmd, ip, mac));
        n_sent++;
        cmd_seen[cmd]++;
        @(negedge clk);
    endtask

    task automatic drain_replies();
        req.valid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_idling(int idle_pct, int stall_pct);
        src_idle_pct  = idle_pct;
        rsp_stall_pct = stall_pct;
    endtask

    task automatic test_empty_cache();
        send_req(CMD_LOOKUP, 32'h0000_0000, 48'h0);
        send_req(CMD_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_req(CMD_INVAL,  32'h1234_5678, 48'h0);
        send_req(CMD_RSVD,   32'h0000_0000, 48'hFFFF_FFFF_FFFF);
        send_req(CMD_RSVD,   32'h0A00_0001, 48'h0);
    endtask

    task automatic test_set_and_evict();
        send_req(CMD_SET,    32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_req(CMD_SET,    32'h0A00_0002, 48'h0);
        send_req(CMD_LOOKUP, 32'hFFFF_FFFF, 48'h0);
        send_req(CMD_SET,    32'hFFFF_FFFF, 48'h0123_4567_89AB);
        for (int i = 0; i < 6; i++)
            send_req(CMD_SET, 32'h0A00_0010 + i, {16'h0200, 32'(i)});
        // table full; ties at count one go to the lowest index
        send_req(CMD_SET,    32'h0A00_0099, 48'h5555_AAAA_5555);
        send_req(CMD_LOOKUP, 32'h0A00_0002, 48'h0);
        send_req(CMD_LOOKUP, 32'h0A00_0099, 48'h0);
        send_req(CMD_INVAL,  32'h0A00_0010, 48'h0);
        // a zero address matches the cleared entry
        send_req(CMD_LOOKUP, 32'h0000_0000, 48'h0);
        send_req(CMD_SET,    32'h0000_0000, 48'hAAAA_5555_AAAA);
        send_req(CMD_LOOKUP, 32'h0000_0000, 48'h0);
        send_req(CMD_LOOKUP, 32'h0A00_0010, 48'h0);
        send_req(CMD_INVAL,  32'h0000_0000, 48'h0);
        send_req(CMD_RSVD,   32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
    endtask

    // Drives one entry's use count to the limit, then checks it is not
    // evicted as if the count had wrapped.
    task automatic test_count_saturation();
        logic [IP_W-1:0] hot;
        int n;
        hot = $urandom;
        n   = 0;
        send_req(CMD_SET, hot, rand_mac());
        while (cache_tab[cache_find(hot)].cnt != COUNT_MAX)
        begin
            send_req(CMD_SET, hot, rand_mac());
            n++;
            if (n % 32 == 0)
                send_req(CMD_LOOKUP, hot, rand_mac());
        end
        for (int i = 0; i < ENTRIES - 1; i++)
            send_req(CMD_SET, $urandom, rand_mac());
        send_req(CMD_SET, hot, rand_mac());
        send_req(CMD_SET, $urandom, rand_mac());
        send_req(CMD_LOOKUP, hot, 48'h0);
    endtask

    task automatic test_random_traffic(int n_items, int idle_pct, int stall_pct);
        logic [CMD_W-1:0] cmd;
        logic [IP_W-1:0]  ip;
        int r;
        set_idling(idle_pct, stall_pct);
        ip_pool[0] = '0;
        ip_pool[1] = '1;
        for (int i = 2; i < POOL; i++)
            ip_pool[i] = $urandom;
        for (int k = 0; k < n_items; k++)
        begin
            r = $urandom_range(99);
            if (r < 35)
                cmd = CMD_LOOKUP;
            else if (r < 75)
                cmd = CMD_SET;
            else if (r < 93)
                cmd = CMD_INVAL;
            else
                cmd = CMD_RSVD;
            if ($urandom_range(99) < 8)
                ip = $urandom;
            else
                ip = ip_pool[$urandom_range(POOL - 1)];
            send_req(cmd, ip, rand_mac());
            if (k == n_items / 2)
                drain_replies();
        end
        drain_replies();
    endtask

    always @(negedge clk)
        rsp.ready <= ($urandom_range(99) >= rsp_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (reply_q.size() == 0)
                flag_error($sformatf("unexpected response hit=%0b mac=%012h",
                                     rsp.hit, rsp.found_mac));
            else
            begin
                head_reply = reply_q.pop_front();
                n_checked++;
                if (head_reply.hit)
                    n_hits++;
                if (rsp.hit !== head_reply.hit)
                    flag_error($sformatf("hit: expected %0b, got %0b",
                                         head_reply.hit, rsp.hit));
                if (rsp.found_mac !== head_reply.mac)
                    flag_error($sformatf("found_mac: expected %012h, got %012h",
                                         head_reply.mac, rsp.found_mac));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        req.valid   = 1'b0;
        req.cmd     = CMD_LOOKUP;
        req.ip_addr = '0;
        req.new_mac = '0;
        rsp.ready   = 1'b0;
        foreach (cache_tab[i])
            cache_tab[i] = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_idling(0, 0);
        test_empty_cache();
        test_set_and_evict();
        drain_replies();
        test_count_saturation();
        drain_replies();
        test_random_traffic(PHASE_ITEMS, 0, 0);
        test_random_traffic(PHASE_ITEMS, 73, 0);
        test_random_traffic(PHASE_ITEMS, 0, 73);
        test_random_traffic(PHASE_ITEMS, 27, 27);

        drain_replies();
        repeat (ENTRIES + 10) @(posedge clk);
        $display("Sent %0d requests (lookup %0d, set %0d, invalidate %0d, unused %0d)",
                 n_sent, cmd_seen[0], cmd_seen[1], cmd_seen[2], cmd_seen[3]);
        $display("Checked %0d responses, %0d hits; eviction ties, zero address, "
                 , n_checked, n_hits, "count saturation and four idle/stall patterns");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
